[rtl/lmtc_pkg.sv]
// Shared types and constants of the LCD mode timing controller.
// No dependencies; used by lmtc_front, lmtc_back and the top level.
package lmtc_pkg;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_LCDC    = 2'd1,
    OP_STAT    = 2'd2,
    OP_LYC     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_END   = 3'd0,
    EV_MODE  = 3'd1,
    EV_LINE  = 3'd2,
    EV_DRAW  = 3'd3,
    EV_FRAME = 3'd4
  } event_t;

  // queued item: decoded opcode and its single operand byte
  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
  } item_t;

  parameter int QDEPTH = 2;
  parameter int QPTR_W = $clog2(QDEPTH);

  parameter logic [1:0] MODE_HBLANK = 2'd0;
  parameter logic [1:0] MODE_VBLANK = 2'd1;
  parameter logic [1:0] MODE_OAM    = 2'd2;
  parameter logic [1:0] MODE_DRAW   = 2'd3;

  parameter logic [11:0] OAM_CLKS     = 12'd82;
  parameter logic [11:0] DRAW_CLKS    = 12'd252;
  parameter logic [11:0] LINE_CLKS    = 12'd456;
  parameter logic [11:0] HBL_CLKS     = 12'd4;
  parameter logic [11:0] L153_CLKS    = 12'd448;
  parameter logic [11:0] SHORT_CLKS   = 12'd8;
  parameter logic [7:0]  VBLANK_LINE  = 8'd144;
  parameter logic [7:0]  LAST_LINE    = 8'd153;
  parameter logic [7:0]  WRAP_LINE    = 8'd154;
  parameter logic [2:0]  EV_LIMIT     = 3'd5;

endpackage

[rtl/lmtc_front.sv]
// Front end: accepts input beats, decodes the opcode and queues items.
// Depends on lmtc_pkg.
module lmtc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // opcode[1:0], clock_count[9:2], write_value[17:10]
  output logic                 q_valid,
  output lmtc_pkg::item_t      q_item,
  input  logic                 q_ready
);

  lmtc_pkg::item_t             entry [lmtc_pkg::QDEPTH];
  logic [lmtc_pkg::QPTR_W-1:0] wr_ptr;
  logic [lmtc_pkg::QPTR_W-1:0] rd_ptr;
  logic [lmtc_pkg::QPTR_W:0]   count;
  lmtc_pkg::item_t             dec_item;
  logic                        push;
  logic                        pop;

  always_comb begin
    dec_item.op      = lmtc_pkg::op_t'(s_axis_tdata[1:0]);
    dec_item.operand = (dec_item.op == lmtc_pkg::OP_ADVANCE) ? s_axis_tdata[9:2]
                                                              : s_axis_tdata[17:10];
  end

  assign s_axis_tready = (count != (lmtc_pkg::QPTR_W+1)'(lmtc_pkg::QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= dec_item;
    end
  end

endmodule

[rtl/lmtc_back.sv]
// Back end: mode/line sequencer, register file and result output register.
// Depends on lmtc_pkg; fed by lmtc_front.
module lmtc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_data,
  input  logic            q_valid,
  input  lmtc_pkg::item_t q_item,
  output logic            q_ready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,  // screen_mode[1:0], line_number[9:2],
                                         // status_byte[17:10], vblank_irq[18], stat_irq[19]
  output logic [2:0]      m_axis_tuser,  // event_kind[2:0]
  output logic            m_axis_tlast   // last_result
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_SECOND = 4'b0100,
    ST_END    = 4'b1000
  } state_t;

  function automatic logic stat_line_f(logic on, logic [1:0] m, logic [7:0] s);
    return on && ((s[6] && s[2]) || (m == lmtc_pkg::MODE_HBLANK && s[3]) ||
                  (m == lmtc_pkg::MODE_VBLANK && s[4]) || (m == lmtc_pkg::MODE_OAM && s[5]));
  endfunction

  state_t      state, state_next;
  logic [2:0]  n_cnt, n_next;
  logic        second_frame, second_frame_next;
  logic        double_speed;
  logic [1:0]  mode_reg, mode_next;
  logic [7:0]  scanline, scanline_next;
  logic [11:0] line_clock, line_clock_next;
  logic        line_drawn, drawn_next;
  logic        display_on, display_next;
  logic [7:0]  control_reg, control_next;
  logic [7:0]  status_reg, status_next;
  logic [7:0]  compare_line, compare_next;
  logic        stat_prev, stat_prev_next;

  logic [11:0] oam_lim, draw_lim, line_lim, lc_sub;
  logic [7:0]  line_inc;
  logic        out_free, out_load;
  lmtc_pkg::event_t ev_kind;
  logic        ev_vb, ev_st, ev_last;

  lmtc_pkg::event_t out_kind;
  logic [1:0]  out_mode;
  logic [7:0]  out_line, out_status;
  logic        out_vb, out_st;

  assign oam_lim  = lmtc_pkg::OAM_CLKS << double_speed;
  assign draw_lim = lmtc_pkg::DRAW_CLKS << double_speed;
  assign line_lim = lmtc_pkg::LINE_CLKS << double_speed;
  assign lc_sub   = line_clock - line_lim;
  assign line_inc = scanline + 8'd1;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next        = state;
    n_next            = n_cnt;
    second_frame_next = second_frame;
    mode_next         = mode_reg;
    scanline_next     = scanline;
    line_clock_next   = line_clock;
    drawn_next        = line_drawn;
    display_next      = display_on;
    control_next      = control_reg;
    status_next       = status_reg;
    compare_next      = compare_line;
    stat_prev_next    = stat_prev;
    q_ready           = 1'b0;
    out_load          = 1'b0;
    ev_kind           = lmtc_pkg::EV_END;
    ev_vb             = 1'b0;
    ev_st             = 1'b0;
    ev_last           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          case (q_item.op)
            lmtc_pkg::OP_ADVANCE: begin
              if (display_on) begin
                line_clock_next = line_clock + {4'd0, q_item.operand};
                n_next          = '0;
                state_next      = ST_RUN;
              end else begin
                out_load = 1'b1;
                ev_last  = 1'b1;
              end
            end
            lmtc_pkg::OP_LCDC: begin
              if (control_reg[7] != q_item.operand[7]) begin
                scanline_next = '0;
                if (q_item.operand[7]) begin
                  line_clock_next = lmtc_pkg::LINE_CLKS;
                  mode_next       = lmtc_pkg::MODE_VBLANK;
                end else begin
                  line_clock_next = '0;
                  mode_next       = lmtc_pkg::MODE_HBLANK;
                end
                status_next    = {status_reg[7:2], mode_next};
                stat_prev_next = stat_line_f(display_on, mode_next, status_next);
              end
              display_next = q_item.operand[7];
              control_next = q_item.operand;
              out_load     = 1'b1;
              ev_last      = 1'b1;
            end
            lmtc_pkg::OP_STAT: begin
              status_next    = {q_item.operand[7:3], status_reg[2:0]};
              stat_prev_next = stat_line_f(display_on, mode_reg, status_next);
              ev_st          = stat_prev_next && !stat_prev;
              out_load       = 1'b1;
              ev_last        = 1'b1;
            end
            lmtc_pkg::OP_LYC: begin
              compare_next = q_item.operand;
              if (display_on) begin
                status_next[2] = (scanline == q_item.operand);
                stat_prev_next = stat_line_f(display_on, mode_reg, status_next);
                ev_st          = stat_prev_next && !stat_prev;
              end
              out_load = 1'b1;
              ev_last  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (n_cnt > lmtc_pkg::EV_LIMIT) begin
            state_next = ST_END;
          end else begin
            case (mode_reg)
              lmtc_pkg::MODE_OAM: begin
                if (line_clock < oam_lim) begin
                  state_next = ST_END;
                end else begin
                  mode_next        = lmtc_pkg::MODE_DRAW;
                  status_next[1:0] = lmtc_pkg::MODE_DRAW;
                  stat_prev_next   = stat_line_f(display_on, mode_next, status_next);
                  ev_st            = stat_prev_next && !stat_prev;
                  ev_kind          = lmtc_pkg::EV_MODE;
                  out_load         = 1'b1;
                  n_next           = n_cnt + 3'd1;
                end
              end
              lmtc_pkg::MODE_DRAW: begin
                if (line_clock < draw_lim) begin
                  state_next = ST_END;
                end else begin
                  ev_kind           = lmtc_pkg::EV_DRAW;
                  out_load          = 1'b1;
                  n_next            = n_cnt + 3'd1;
                  second_frame_next = 1'b0;
                  state_next        = ST_SECOND;
                end
              end
              lmtc_pkg::MODE_HBLANK: begin
                if (!line_drawn) begin
                  if (line_clock < lmtc_pkg::HBL_CLKS) begin
                    state_next = ST_END;
                  end else begin
                    status_next[2] = (scanline == compare_line);
                    if (scanline == lmtc_pkg::VBLANK_LINE) begin
                      mode_next = lmtc_pkg::MODE_VBLANK;
                      ev_vb     = 1'b1;
                    end else begin
                      mode_next = lmtc_pkg::MODE_OAM;
                    end
                    status_next[1:0] = mode_next;
                    stat_prev_next   = stat_line_f(display_on, mode_next, status_next);
                    ev_st            = stat_prev_next && !stat_prev;
                    ev_kind          = lmtc_pkg::EV_MODE;
                    out_load         = 1'b1;
                    n_next           = n_cnt + 3'd1;
                  end
                end else if (line_clock < line_lim) begin
                  state_next = ST_END;
                end else begin
                  line_clock_next = lc_sub;
                  scanline_next   = line_inc;
                  drawn_next      = 1'b0;
                  ev_kind         = lmtc_pkg::EV_LINE;
                  out_load        = 1'b1;
                  n_next          = n_cnt + 3'd1;
                end
              end
              lmtc_pkg::MODE_VBLANK: begin
                if (line_clock < line_lim) begin
                  state_next = ST_END;
                end else begin
                  line_clock_next = lc_sub;
                  if (scanline == '0) begin
                    mode_next        = lmtc_pkg::MODE_OAM;
                    status_next[1:0] = lmtc_pkg::MODE_OAM;
                    ev_kind          = lmtc_pkg::EV_MODE;
                  end else begin
                    scanline_next = line_inc;
                    if (line_inc == lmtc_pkg::LAST_LINE) begin
                      line_clock_next = lc_sub + (lmtc_pkg::L153_CLKS << double_speed);
                    end else if (line_inc == lmtc_pkg::WRAP_LINE) begin
                      scanline_next     = '0;
                      line_clock_next   = lc_sub + (lmtc_pkg::SHORT_CLKS << double_speed);
                      second_frame_next = 1'b1;
                      state_next        = ST_SECOND;
                    end
                    status_next[2] = (scanline_next == compare_line);
                    ev_kind        = lmtc_pkg::EV_LINE;
                  end
                  stat_prev_next = stat_line_f(display_on, mode_next, status_next);
                  ev_st          = stat_prev_next && !stat_prev;
                  out_load       = 1'b1;
                  n_next         = n_cnt + 3'd1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          out_load   = 1'b1;
          n_next     = n_cnt + 3'd1;
          state_next = ST_RUN;
          if (second_frame) begin
            ev_kind = lmtc_pkg::EV_FRAME;
          end else begin
            mode_next        = lmtc_pkg::MODE_HBLANK;
            status_next[1:0] = lmtc_pkg::MODE_HBLANK;
            drawn_next       = 1'b1;
            stat_prev_next   = stat_line_f(display_on, mode_next, status_next);
            ev_st            = stat_prev_next && !stat_prev;
            ev_kind          = lmtc_pkg::EV_MODE;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_load   = 1'b1;
          ev_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      n_cnt         <= '0;
      second_frame  <= 1'b0;
      double_speed  <= 1'b0;
      mode_reg      <= '0;
      scanline      <= '0;
      line_clock    <= '0;
      line_drawn    <= 1'b0;
      display_on    <= 1'b0;
      control_reg   <= '0;
      status_reg    <= '0;
      compare_line  <= '0;
      stat_prev     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state        <= state_next;
      n_cnt        <= n_next;
      second_frame <= second_frame_next;
      mode_reg     <= mode_next;
      scanline     <= scanline_next;
      line_clock   <= line_clock_next;
      line_drawn   <= drawn_next;
      display_on   <= display_next;
      control_reg  <= control_next;
      status_reg   <= status_next;
      compare_line <= compare_next;
      stat_prev    <= stat_prev_next;
      if (cfg_valid) begin
        double_speed <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload, taken from the state after the event
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind     <= ev_kind;
      out_mode     <= mode_next;
      out_line     <= scanline_next;
      out_status   <= status_next;
      out_vb       <= ev_vb;
      out_st       <= ev_st;
      m_axis_tlast <= ev_last;
    end
  end

  assign m_axis_tdata = {4'd0, out_st, out_vb, out_status, out_line, out_mode};
  assign m_axis_tuser = out_kind;

`ifndef SYNTH
  a_mode_in_stat: assert property (@(posedge clk) disable iff (rst)
    status_reg[1:0] == mode_reg)
    else $error("STAT mode bits differ from mode register");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    scanline <= lmtc_pkg::LAST_LINE)
    else $error("scanline beyond last line");

  a_off_is_idle: assert property (@(posedge clk) disable iff (rst)
    !display_on |-> (state == ST_IDLE || state == ST_END))
    else $error("sequencer running with display off");

  a_second_from_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECOND && $past(state) != ST_SECOND) |-> $past(state) == ST_RUN)
    else $error("second event entered outside an advance");
`endif

endmodule

[rtl/lcd_mode_timing_controller_unit.sv]
// Top level of the LCD mode timing controller.
// Depends on lmtc_pkg, lmtc_front and lmtc_back.
//
// Scanline mode sequencer (OAM, draw, hblank, vblank) driven by advance and
// register-write items. The front end queues up to two items; the sequencer
// in the back end then produces result beats through its output register and
// holds while that register is stalled. A write item, or an advance while the
// display is off, gives only its end report. An advance reports 0 to 7
// events: it first adds the clocks, then gives one result per event, then
// finds no further event due (or the event limit reached) and gives the end
// report. The double_speed register is written on the cfg channel, which is
// always ready.
module lcd_mode_timing_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // double_speed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // opcode[1:0], clock_count[9:2], write_value[17:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // screen_mode[1:0], line_number[9:2],
                                      // status_byte[17:10], vblank_irq[18], stat_irq[19]
  output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
  output logic        m_axis_tlast    // last_result
);

  logic            q_valid;
  logic            q_ready;
  lmtc_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  lmtc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready)
  );

  lmtc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
